>>> rtl/enigma_pkg.sv
// Shared types, constants and wiring tables of the three-rotor rotor cipher.
// Holds the rotor and reflector permutations with their inverses and mod-26 helpers.
// Depends on nothing; used by three_rotor_enigma_cipher.
`default_nettype none

package enigma_pkg;

   localparam int NUM_LETTERS     = 26;
   localparam int LETTER_WIDTH    = 5;
   localparam int CHAR_WIDTH      = 8;
   localparam int NUM_ROTORS      = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 5;

   typedef logic [LETTER_WIDTH-1:0]    letter_type;
   typedef logic [CHAR_WIDTH-1:0]      char_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_START_FAST   = 2'd0;
   localparam csr_index_type CSR_START_MIDDLE = 2'd1;
   localparam csr_index_type CSR_START_SLOW   = 2'd2;
   localparam csr_index_type CSR_DECRYPT_MODE = 2'd3;

   // Rotor numbering within the position array.
   localparam int ROTOR_FAST   = 0;
   localparam int ROTOR_MIDDLE = 1;
   localparam int ROTOR_SLOW   = 2;

   localparam char_type ASCII_SPACE   = 8'h20;
   localparam char_type ASCII_UPPER_A = 8'h41;
   localparam char_type ASCII_UPPER_Z = 8'h5A;
   localparam char_type ASCII_LOWER_A = 8'h61;
   localparam char_type ASCII_LOWER_Z = 8'h7A;

   localparam letter_type LAST_LETTER = letter_type'(NUM_LETTERS - 1);

   // Wiring MVCBXLPQAFUKJZDHRTEYINGSWO and its inverse.
   localparam letter_type FAST_FWD [NUM_LETTERS] = '{
      5'd12, 5'd21, 5'd2,  5'd1,  5'd23, 5'd11, 5'd15, 5'd16, 5'd0,  5'd5,
      5'd20, 5'd10, 5'd9,  5'd25, 5'd3,  5'd7,  5'd17, 5'd19, 5'd4,  5'd24,
      5'd8,  5'd13, 5'd6,  5'd18, 5'd22, 5'd14};
   localparam letter_type FAST_INV [NUM_LETTERS] = '{
      5'd8,  5'd3,  5'd2,  5'd14, 5'd18, 5'd9,  5'd22, 5'd15, 5'd20, 5'd12,
      5'd11, 5'd5,  5'd0,  5'd21, 5'd25, 5'd6,  5'd7,  5'd16, 5'd23, 5'd17,
      5'd10, 5'd1,  5'd24, 5'd4,  5'd19, 5'd13};

   // Wiring TNLOCKMZEPGWBIVXSDJQFRAUHY and its inverse.
   localparam letter_type MIDDLE_FWD [NUM_LETTERS] = '{
      5'd19, 5'd13, 5'd11, 5'd14, 5'd2,  5'd10, 5'd12, 5'd25, 5'd4,  5'd15,
      5'd6,  5'd22, 5'd1,  5'd8,  5'd21, 5'd23, 5'd18, 5'd3,  5'd9,  5'd16,
      5'd5,  5'd17, 5'd0,  5'd20, 5'd7,  5'd24};
   localparam letter_type MIDDLE_INV [NUM_LETTERS] = '{
      5'd22, 5'd12, 5'd4,  5'd17, 5'd8,  5'd20, 5'd10, 5'd24, 5'd13, 5'd18,
      5'd5,  5'd2,  5'd6,  5'd1,  5'd3,  5'd9,  5'd19, 5'd21, 5'd16, 5'd0,
      5'd23, 5'd14, 5'd11, 5'd15, 5'd25, 5'd7};

   // Wiring BDFHJLCPRTXVNZYEIWGAKMUSQO and its inverse.
   localparam letter_type SLOW_FWD [NUM_LETTERS] = '{
      5'd1,  5'd3,  5'd5,  5'd7,  5'd9,  5'd11, 5'd2,  5'd15, 5'd17, 5'd19,
      5'd23, 5'd21, 5'd13, 5'd25, 5'd24, 5'd4,  5'd8,  5'd22, 5'd6,  5'd0,
      5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
   localparam letter_type SLOW_INV [NUM_LETTERS] = '{
      5'd19, 5'd0,  5'd6,  5'd1,  5'd15, 5'd2,  5'd18, 5'd3,  5'd16, 5'd4,
      5'd20, 5'd5,  5'd21, 5'd12, 5'd25, 5'd7,  5'd24, 5'd8,  5'd23, 5'd9,
      5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd13};

   // Reflector WJDZUIKHYRMQPSALOXFCNTBVEG and its inverse.
   localparam letter_type REFL_FWD [NUM_LETTERS] = '{
      5'd22, 5'd9,  5'd3,  5'd25, 5'd20, 5'd8,  5'd10, 5'd7,  5'd24, 5'd17,
      5'd12, 5'd16, 5'd15, 5'd18, 5'd0,  5'd11, 5'd14, 5'd23, 5'd5,  5'd2,
      5'd13, 5'd19, 5'd1,  5'd21, 5'd4,  5'd6};
   localparam letter_type REFL_INV [NUM_LETTERS] = '{
      5'd14, 5'd22, 5'd19, 5'd2,  5'd24, 5'd18, 5'd25, 5'd7,  5'd5,  5'd1,
      5'd6,  5'd15, 5'd10, 5'd20, 5'd16, 5'd12, 5'd11, 5'd9,  5'd13, 5'd21,
      5'd4,  5'd23, 5'd0,  5'd17, 5'd8,  5'd3};

   // Sum of two letters, both below 26, folded back into 0..25.
   function automatic letter_type add_mod(input letter_type a, input letter_type b);
      logic [LETTER_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (LETTER_WIDTH+1)'(NUM_LETTERS)) begin
         sum = sum - (LETTER_WIDTH+1)'(NUM_LETTERS);
      end
      return sum[LETTER_WIDTH-1:0];
   endfunction

   // Difference of two letters, both below 26, folded back into 0..25.
   function automatic letter_type sub_mod(input letter_type a, input letter_type b);
      logic [LETTER_WIDTH:0] diff;
      if (a >= b) begin
         diff = {1'b0, a} - {1'b0, b};
      end else begin
         diff = {1'b0, a} + (LETTER_WIDTH+1)'(NUM_LETTERS) - {1'b0, b};
      end
      return diff[LETTER_WIDTH-1:0];
   endfunction

   // Start value of 0..31 reduced to a rotor position.
   function automatic letter_type fold_start(input letter_type v);
      letter_type r;
      r = v;
      if (v >= letter_type'(NUM_LETTERS)) begin
         r = v - letter_type'(NUM_LETTERS);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/three_rotor_enigma_cipher.sv
// Top level of the three-rotor rotor cipher: input stage, rotor odometer,
// cipher datapath and output register. Depends on enigma_pkg.
`default_nettype none

// Three-rotor rotor cipher, one ASCII byte per transaction. The block accepts
// one transaction every clock cycle while the result side does not stall; each
// byte is registered in the input stage and its result in the output register. The
// rate is set by the rotor odometer: positions are stepped at the moment a letter is
// accepted, so each letter carries its own rotor positions down the pipe and the
// next letter sees the stepped rotors in the very next cycle. Letters of either
// case come out as upper-case cipher letters; any other byte passes through
// unchanged and does not step the rotors. In encrypt mode a space is consumed and
// produces no result. Writing a start register loads the matching running
// rotor position (values 26..31 wrap by 26); configuration must be written
// only while no transaction is in flight.
module three_rotor_enigma_cipher (
   input  wire                                 clock,
   input  wire                                 reset,
   // Input channel.
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [enigma_pkg::CHAR_WIDTH-1:0]   req_char_in,
   // Result channel.
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [enigma_pkg::CHAR_WIDTH-1:0]   rsp_char_out,
   // Configuration write port.
   input  wire                                 csr_write_en,
   input  wire  [enigma_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [enigma_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Running rotor positions and the mode bit.
   enigma_pkg::letter_type pos_ff [enigma_pkg::NUM_ROTORS];
   enigma_pkg::letter_type pos_in [enigma_pkg::NUM_ROTORS];
   logic                   decrypt_mode_ff;
   logic                   decrypt_mode_in;

   // Input stage: the accepted byte, its letter index and the rotor
   // positions it is to be enciphered with.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_letter_ff, s1_letter_in;
   enigma_pkg::letter_type s1_index_ff, s1_index_in;
   enigma_pkg::char_type   s1_char_ff, s1_char_in;
   enigma_pkg::letter_type s1_pos_ff [enigma_pkg::NUM_ROTORS];
   enigma_pkg::letter_type s1_pos_in [enigma_pkg::NUM_ROTORS];

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   enigma_pkg::char_type   rsp_char_ff, rsp_char_in;

   logic req_fire;
   logic s2_load;
   logic s1_advance;
   logic is_upper;
   logic is_lower;
   logic keep_item;
   enigma_pkg::char_type letter_offset;

   enigma_pkg::letter_type fwd_fast, fwd_middle, fwd_slow, reflected;
   enigma_pkg::letter_type back_slow, back_middle, back_fast;

   // The output register loads whenever it is empty or being drained, and the
   // input stage moves forward into it at the same time.
   assign s2_load    = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && s2_load;
   assign req_stall  = s1_valid_ff && !s2_load;
   assign req_fire   = req_valid && !req_stall;

   // Character classification of the incoming byte.
   assign is_upper = req_char_in inside {[enigma_pkg::ASCII_UPPER_A:enigma_pkg::ASCII_UPPER_Z]};
   assign is_lower = req_char_in inside {[enigma_pkg::ASCII_LOWER_A:enigma_pkg::ASCII_LOWER_Z]};
   // A space in encrypt mode is swallowed without a result.
   assign keep_item = !((req_char_in == enigma_pkg::ASCII_SPACE) && !decrypt_mode_ff);
   assign letter_offset = is_lower ? (req_char_in - enigma_pkg::ASCII_LOWER_A)
                                   : (req_char_in - enigma_pkg::ASCII_UPPER_A);

   // Rotor odometer and configuration writes. The user must keep a configuration
   // write from coinciding with traffic; the block does not enforce it, and a write takes priority.
   always_comb begin
      pos_in          = pos_ff;
      decrypt_mode_in = decrypt_mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            enigma_pkg::CSR_START_FAST: begin
               pos_in[enigma_pkg::ROTOR_FAST] = enigma_pkg::fold_start(csr_wdata);
            end
            enigma_pkg::CSR_START_MIDDLE: begin
               pos_in[enigma_pkg::ROTOR_MIDDLE] = enigma_pkg::fold_start(csr_wdata);
            end
            enigma_pkg::CSR_START_SLOW: begin
               pos_in[enigma_pkg::ROTOR_SLOW] = enigma_pkg::fold_start(csr_wdata);
            end
            enigma_pkg::CSR_DECRYPT_MODE: begin
               decrypt_mode_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end else if (req_fire && (is_upper || is_lower)) begin
         // The fast rotor steps on every letter; the middle one steps when
         // the fast one wraps, and the slow one only when the middle wraps.
         pos_in[enigma_pkg::ROTOR_FAST] =
            enigma_pkg::add_mod(pos_ff[enigma_pkg::ROTOR_FAST], 5'd1);
         if (pos_ff[enigma_pkg::ROTOR_FAST] == enigma_pkg::LAST_LETTER) begin
            pos_in[enigma_pkg::ROTOR_MIDDLE] =
               enigma_pkg::add_mod(pos_ff[enigma_pkg::ROTOR_MIDDLE], 5'd1);
            if (pos_ff[enigma_pkg::ROTOR_MIDDLE] == enigma_pkg::LAST_LETTER) begin
               pos_in[enigma_pkg::ROTOR_SLOW] =
                  enigma_pkg::add_mod(pos_ff[enigma_pkg::ROTOR_SLOW], 5'd1);
            end
         end
      end
   end

   // Input stage next values.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_letter_in = s1_letter_ff;
      s1_index_in  = s1_index_ff;
      s1_char_in   = s1_char_ff;
      s1_pos_in    = s1_pos_ff;
      if (req_fire) begin
         s1_valid_in  = keep_item;
         s1_letter_in = is_upper || is_lower;
         s1_index_in  = letter_offset[enigma_pkg::LETTER_WIDTH-1:0];
         s1_char_in   = req_char_in;
         s1_pos_in    = pos_ff;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Cipher datapath: three forward rotor passes (mod-26 add, then table lookup),
   // the reflector lookup, and three inverse passes (lookup, then mod-26 subtract).
   always_comb begin
      fwd_fast   = enigma_pkg::FAST_FWD[enigma_pkg::add_mod(s1_index_ff,
                                        s1_pos_ff[enigma_pkg::ROTOR_FAST])];
      fwd_middle = enigma_pkg::MIDDLE_FWD[enigma_pkg::add_mod(fwd_fast,
                                          s1_pos_ff[enigma_pkg::ROTOR_MIDDLE])];
      fwd_slow   = enigma_pkg::SLOW_FWD[enigma_pkg::add_mod(fwd_middle,
                                        s1_pos_ff[enigma_pkg::ROTOR_SLOW])];
      // The reflector is not its own inverse, so decryption uses the inverse map.
      reflected  = decrypt_mode_ff ? enigma_pkg::REFL_INV[fwd_slow]
                                   : enigma_pkg::REFL_FWD[fwd_slow];
      back_slow   = enigma_pkg::sub_mod(enigma_pkg::SLOW_INV[reflected],
                                        s1_pos_ff[enigma_pkg::ROTOR_SLOW]);
      back_middle = enigma_pkg::sub_mod(enigma_pkg::MIDDLE_INV[back_slow],
                                        s1_pos_ff[enigma_pkg::ROTOR_MIDDLE]);
      back_fast   = enigma_pkg::sub_mod(enigma_pkg::FAST_INV[back_middle],
                                        s1_pos_ff[enigma_pkg::ROTOR_FAST]);
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      if (s2_load) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_advance) begin
         rsp_char_in = s1_letter_ff
                       ? (enigma_pkg::ASCII_UPPER_A + {3'b000, back_fast})
                       : s1_char_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '{default: '0};
         decrypt_mode_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pos_ff          <= pos_in;
         decrypt_mode_ff <= decrypt_mode_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_letter_ff <= s1_letter_in;
      s1_index_ff  <= s1_index_in;
      s1_char_ff   <= s1_char_in;
      s1_pos_ff    <= s1_pos_in;
      rsp_char_ff  <= rsp_char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;

endmodule

`default_nettype wire
